/* rtl/bfr_pkg.sv */
// Shared types and constants of the brightness fade ramp.
// No dependencies; imported by every module of the block.
package bfr_pkg;

  localparam int unsigned NUM_CHAN = 2;
  localparam int unsigned LVL_W    = 6;
  localparam int unsigned STEPS_W  = 8;
  localparam int unsigned PLANES_W = 6;
  localparam int unsigned QUO_W    = 6;
  localparam int unsigned ACC_W    = 9;
  localparam int unsigned CNT_W    = 3;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_SET    = 2'd2,
    OP_CANCEL = 2'd3
  } op_e;

  // Per-channel update command, valid for one cycle.
  typedef struct packed {
    logic                tick;
    logic                load;
    logic                clear;
    logic [LVL_W-1:0]    level;
    logic [LVL_W-1:0]    target;
    logic [STEPS_W-1:0]  steps;
    logic [PLANES_W-1:0] planes;
    logic                dir;
    logic [QUO_W-1:0]    quot;
    logic [STEPS_W-1:0]  rem;
  } chan_cmd_t;

  // Per-channel status toward the sequencer.
  typedef struct packed {
    logic                busy;
    logic [LVL_W-1:0]    next_level;
    logic [PLANES_W-1:0] planes;
  } chan_sts_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

/* rtl/bfr_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bfr_pkg.
module bfr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bfr_pkg::QUO_W-1:0]    dividend_i,
  input  logic [bfr_pkg::STEPS_W-1:0]  divisor_i,
  output bfr_pkg::div_sts_t            sts_o,
  output logic [bfr_pkg::QUO_W-1:0]    quotient_o,
  output logic [bfr_pkg::STEPS_W-1:0]  remainder_o
);
  import bfr_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [QUO_W-1:0]    dvd_q, dvd_d;
  logic [STEPS_W-1:0]  rem_q, rem_d;
  logic [STEPS_W-1:0]  dvs_q, dvs_d;
  logic [STEPS_W:0]    trial;
  logic                fits;

  assign trial = {rem_q, dvd_q[QUO_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUO_W);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? STEPS_W'(trial - {1'b0, dvs_q}) : trial[STEPS_W-1:0];
      dvd_d = {dvd_q[QUO_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign sts_o.busy  = busy_q;
  assign sts_o.done  = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

/* rtl/bfr_chan.sv */
// One fade channel: ramp state and the DDA tick step.
// Depends on bfr_pkg.
module bfr_chan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bfr_pkg::chan_cmd_t cmd_i,
  output bfr_pkg::chan_sts_t sts_o
);
  import bfr_pkg::*;

  logic                busy_q, busy_d;
  logic [LVL_W-1:0]    level_q, level_d;
  logic                dir_q, dir_d;
  logic [QUO_W-1:0]    quot_q, quot_d;
  logic [STEPS_W-1:0]  rem_q, rem_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [STEPS_W-1:0]  steps_q, steps_d;
  logic [LVL_W-1:0]    target_q, target_d;
  logic [PLANES_W-1:0] planes_q, planes_d;

  // tick arithmetic, one bit wider than a level
  logic [LVL_W:0]   lvl_x, tgt_x, quo_x, step_x, extra_x;
  logic [ACC_W-1:0] acc_sum;
  logic [LVL_W-1:0] tick_level;
  logic [ACC_W-1:0] tick_acc;
  logic             tick_done;

  assign lvl_x   = {level_q[LVL_W-1], level_q};
  assign tgt_x   = {target_q[LVL_W-1], target_q};
  assign quo_x   = {1'b0, quot_q};
  assign step_x  = dir_q ? lvl_x - quo_x : lvl_x + quo_x;
  assign extra_x = dir_q ? step_x - 1'b1 : step_x + 1'b1;
  assign acc_sum = acc_q + {1'b0, rem_q};

  always_comb begin
    tick_level = target_q;
    tick_acc   = acc_q;
    tick_done  = 1'b1;
    if (step_x != tgt_x && lvl_x != tgt_x) begin
      tick_level = step_x[LVL_W-1:0];
      tick_acc   = acc_sum;
      tick_done  = 1'b0;
      if (acc_sum >= {1'b0, steps_q}) begin
        tick_level = extra_x[LVL_W-1:0];
        if (extra_x != tgt_x) begin
          tick_acc = acc_sum - {1'b0, steps_q};
        end else begin
          tick_done = 1'b1;
        end
      end
    end
  end

  always_comb begin
    busy_d   = busy_q;
    level_d  = level_q;
    dir_d    = dir_q;
    quot_d   = quot_q;
    rem_d    = rem_q;
    acc_d    = acc_q;
    steps_d  = steps_q;
    target_d = target_q;
    planes_d = planes_q;
    if (cmd_i.load) begin
      busy_d   = 1'b1;
      level_d  = cmd_i.level;
      dir_d    = cmd_i.dir;
      quot_d   = cmd_i.quot;
      rem_d    = cmd_i.rem;
      acc_d    = '0;
      steps_d  = cmd_i.steps;
      target_d = cmd_i.target;
      planes_d = cmd_i.planes;
    end else if (cmd_i.clear) begin
      busy_d   = 1'b0;
      level_d  = '0;
      dir_d    = 1'b0;
      quot_d   = '0;
      rem_d    = '0;
      acc_d    = '0;
      steps_d  = '0;
      target_d = '0;
      planes_d = '0;
    end else if (cmd_i.tick && busy_q) begin
      level_d = tick_level;
      acc_d   = tick_acc;
      busy_d  = !tick_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q  <= level_d;
    dir_q    <= dir_d;
    quot_q   <= quot_d;
    rem_q    <= rem_d;
    acc_q    <= acc_d;
    steps_q  <= steps_d;
    target_q <= target_d;
    planes_q <= planes_d;
  end

  assign sts_o.busy       = busy_q;
  assign sts_o.next_level = tick_level;
  assign sts_o.planes     = planes_q;

endmodule

/* rtl/brightness_fade_ramp.sv */
// Top level of the two-channel brightness fade ramp: sequencer, result slots
// and output register. Depends on bfr_pkg, bfr_div and bfr_chan.
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i/in_stall_o   op, screens, steps, start/target level, planes
//   out      out  out_valid_o/out_stall_i write_valid, screen, plane_mask, level,
//                                         busy_main, busy_sub, error, last
//
// Flow: a start passes through accept, the divider, the done check, the update
// and one or two emit beats; tick, set-now and cancel skip the divider. The
// divider resolves one quotient bit of |start - target| / steps per cycle.
// One item at a time: in_stall_o is high from accept until the last result
// beat is loaded into the output register. Output stalls hold the register
// and the sequencer. Reset (rst_ni low) idles all channels and empties output.
module brightness_fade_ramp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input beats
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [1:0]                    screens_i,
  input  logic [bfr_pkg::STEPS_W-1:0]   steps_i,
  input  logic signed [bfr_pkg::LVL_W-1:0] start_level_i,
  input  logic signed [bfr_pkg::LVL_W-1:0] target_level_i,
  input  logic [bfr_pkg::PLANES_W-1:0]  planes_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          write_valid_o,
  output logic                          screen_o,
  output logic [bfr_pkg::PLANES_W-1:0]  plane_mask_o,
  output logic signed [bfr_pkg::LVL_W-1:0] level_o,
  output logic                          busy_main_o,
  output logic                          busy_sub_o,
  output logic                          error_o,
  output logic                          last_o
);
  import bfr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // captured input beat
  op_e                 op_q;
  logic [1:0]          scr_q;
  logic [STEPS_W-1:0]  steps_q;
  logic [LVL_W-1:0]    start_q, target_q;
  logic [PLANES_W-1:0] planes_q;
  logic                dir_q;
  logic                err_q, err_d;

  // pending results, slot i belongs to channel i
  logic [NUM_CHAN-1:0] slot_vld_q, slot_vld_d;
  logic [LVL_W-1:0]    slot_lvl_q [NUM_CHAN];
  logic [PLANES_W-1:0] slot_pln_q [NUM_CHAN];

  logic                in_acc;
  logic                out_free;
  logic [LVL_W:0]      diff;
  logic [QUO_W-1:0]    mag;

  div_sts_t            div_sts;
  logic [QUO_W-1:0]    div_quot;
  logic [STEPS_W-1:0]  div_rem;

  chan_cmd_t           cmd  [NUM_CHAN];
  chan_sts_t           csts [NUM_CHAN];
  logic                is_load;

  // output register
  logic                ov_q, ov_d;
  logic                wv_q, scr_o_q, busy0_q, busy1_q, oerr_q, last_q;
  logic [PLANES_W-1:0] pm_q;
  logic [LVL_W-1:0]    lvl_o_q;
  logic                load_out;
  logic                ld_wv, ld_scr, ld_last;
  logic [PLANES_W-1:0] ld_pm;
  logic [LVL_W-1:0]    ld_lvl;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !ov_q || !out_stall_i;

  // |start - target| feeds the divider straight from the beat
  assign diff = {start_level_i[LVL_W-1], start_level_i}
              - {target_level_i[LVL_W-1], target_level_i};
  assign mag  = diff[LVL_W] ? QUO_W'(-diff) : diff[QUO_W-1:0];

  bfr_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc && op_e'(op_i) == OP_START),
    .dividend_i  (mag),
    .divisor_i   (steps_i),
    .sts_o       (div_sts),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  assign is_load = (op_q == OP_START) && (steps_q != '0);

  for (genvar i = 0; i < NUM_CHAN; i++) begin : g_chan
    always_comb begin
      cmd[i].tick   = (state_q == ST_UPD) && (op_q == OP_TICK);
      cmd[i].load   = (state_q == ST_UPD) && is_load && scr_q[i];
      cmd[i].clear  = (state_q == ST_UPD) && scr_q[i]
                   && (op_q == OP_SET || op_q == OP_CANCEL);
      cmd[i].level  = start_q;
      cmd[i].target = target_q;
      cmd[i].steps  = steps_q;
      cmd[i].planes = planes_q;
      cmd[i].dir    = dir_q;
      cmd[i].quot   = div_quot;
      cmd[i].rem    = div_rem;
    end

    bfr_chan u_chan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd[i]),
      .sts_o  (csts[i])
    );

    // result slot fill during the update cycle
    always_ff @(posedge clk_i) begin
      if (state_q == ST_UPD) begin
        slot_lvl_q[i] <= (op_q == OP_TICK) ? csts[i].next_level : start_q;
        slot_pln_q[i] <= (op_q == OP_TICK) ? csts[i].planes : planes_q;
      end
    end
  end

  // emit order: main first, then sub, else one empty status beat
  always_comb begin
    ld_wv   = 1'b0;
    ld_scr  = 1'b0;
    ld_pm   = '0;
    ld_lvl  = '0;
    ld_last = 1'b1;
    if (slot_vld_q[0]) begin
      ld_wv   = 1'b1;
      ld_pm   = slot_pln_q[0];
      ld_lvl  = slot_lvl_q[0];
      ld_last = !slot_vld_q[1];
    end else if (slot_vld_q[1]) begin
      ld_wv  = 1'b1;
      ld_scr = 1'b1;
      ld_pm  = slot_pln_q[1];
      ld_lvl = slot_lvl_q[1];
    end
  end

  always_comb begin
    state_d    = state_q;
    slot_vld_d = slot_vld_q;
    err_d      = err_q;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (op_e'(op_i) == OP_START) ? ST_DIV : ST_UPD;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        err_d = is_load && ((scr_q[0] && csts[0].busy) || (scr_q[1] && csts[1].busy));
        for (int i = 0; i < NUM_CHAN; i++) begin
          slot_vld_d[i] = ((op_q == OP_TICK) && csts[i].busy)
                       || (is_load && scr_q[i])
                       || ((op_q == OP_SET) && scr_q[i]);
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (slot_vld_q[0]) begin
            slot_vld_d[0] = 1'b0;
          end else begin
            slot_vld_d[1] = 1'b0;
          end
          if (ld_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (load_out) begin
      ov_d = 1'b1;
    end else if (!out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      slot_vld_q <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      slot_vld_q <= slot_vld_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q <= err_d;
    if (in_acc) begin
      op_q     <= op_e'(op_i);
      scr_q    <= screens_i;
      steps_q  <= steps_i;
      start_q  <= start_level_i;
      target_q <= target_level_i;
      planes_q <= planes_i;
      dir_q    <= !diff[LVL_W] && (diff != '0);
    end
    if (load_out) begin
      wv_q    <= ld_wv;
      scr_o_q <= ld_scr;
      pm_q    <= ld_pm;
      lvl_o_q <= ld_lvl;
      busy0_q <= csts[0].busy;
      busy1_q <= csts[1].busy;
      oerr_q  <= err_q;
      last_q  <= ld_last;
    end
  end

  assign out_valid_o   = ov_q;
  assign write_valid_o = wv_q;
  assign screen_o      = scr_o_q;
  assign plane_mask_o  = pm_q;
  assign level_o       = lvl_o_q;
  assign busy_main_o   = busy0_q;
  assign busy_sub_o    = busy1_q;
  assign error_o       = oerr_q;
  assign last_o        = last_q;

endmodule

/* rtl/bfr_check.sv */
// Port-level checker of the brightness fade ramp and its bind.
// Depends on bfr_pkg and brightness_fade_ramp.
module bfr_check (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          write_valid_o,
  input logic                          screen_o,
  input logic [bfr_pkg::PLANES_W-1:0]  plane_mask_o,
  input logic [bfr_pkg::LVL_W-1:0]     level_o,
  input logic                          error_o,
  input logic                          last_o
);
  import bfr_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(level_o)
      && $stable(plane_mask_o) && $stable(last_o))
    else $error("stalled result beat changed");

  // a non-last beat is always followed by the rest of the item
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("gap inside a multi-beat item");

  // no new item while the current one still owes beats
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input taken while results pending");

  // only a main-screen write can precede another beat
  a_first_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> write_valid_o && !screen_o)
    else $error("bad first beat of a two-beat item");

  // a start error always comes with a write; an empty beat is the last
  a_err_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_o || !write_valid_o) |-> (write_valid_o || last_o)
      && (!error_o || write_valid_o))
    else $error("error or empty beat inconsistent");

endmodule

bind brightness_fade_ramp bfr_check u_bfr_check (.*);

/* dv/tb.sv */
// Self-checking testbench for brightness_fade_ramp: queued fade commands, a
// transaction-level predictor of both fade channels, and a result-beat scoreboard.
// Depends on bfr_pkg and the brightness_fade_ramp RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfr_pkg::*;

  typedef struct {
    op_e                op;
    logic [1:0]         screens;
    logic [7:0]         steps;
    logic signed [5:0]  start_lvl;
    logic signed [5:0]  target_lvl;
    logic [5:0]         planes;
  } fade_cmd_t;

  typedef struct {
    logic              write_valid;
    logic              screen;
    logic [5:0]        plane_mask;
    logic signed [5:0] level;
    logic              busy_main;
    logic              busy_sub;
    logic              error;
    logic              last;
  } bright_beat_t;

  // Per-channel fade state, kept in plain integers for the DDA math.
  typedef struct {
    int       level;
    int       target;
    bit       down;
    int       quot;
    int       rem;
    int       acc;
    int       steps;
    bit [5:0] planes;
    bit       busy;
  } fade_chan_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [1:0]                  op_i = OP_TICK;
  logic [1:0]                  screens_i = '0;
  logic [STEPS_W-1:0]          steps_i = '0;
  logic signed [LVL_W-1:0]     start_level_i = '0;
  logic signed [LVL_W-1:0]     target_level_i = '0;
  logic [PLANES_W-1:0]         planes_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic                        write_valid_o;
  logic                        screen_o;
  logic [PLANES_W-1:0]         plane_mask_o;
  logic signed [LVL_W-1:0]     level_o;
  logic                        busy_main_o;
  logic                        busy_sub_o;
  logic                        error_o;
  logic                        last_o;

  fade_cmd_t    fade_cmds[$];
  bright_beat_t bright_due[$];
  fade_chan_t   chan[2];
  fade_cmd_t    cur_cmd;
  bit           cmd_taken;
  int           n_taken;
  int           n_errors;
  logic         quiet;

  // No idling on either side for a stretch in the middle of the run.
  assign quiet = (n_taken >= 600) && (n_taken < 900);

  brightness_fade_ramp u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .screens_i      (screens_i),
    .steps_i        (steps_i),
    .start_level_i  (start_level_i),
    .target_level_i (target_level_i),
    .planes_i       (planes_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_valid_o  (write_valid_o),
    .screen_o       (screen_o),
    .plane_mask_o   (plane_mask_o),
    .level_o        (level_o),
    .busy_main_o    (busy_main_o),
    .busy_sub_o     (busy_sub_o),
    .error_o        (error_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- helpers

  task automatic report_mismatch(string what);
    n_errors++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [5:0] got, logic [5:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic int rand_level();
    return int'($urandom_range(0, 32)) - 16;
  endfunction

  task automatic queue_cmd(op_e op, int screens, int steps, int start_lvl, int target_lvl,
                           int planes);
    fade_cmd_t c;
    c.op         = op;
    c.screens    = 2'(screens);
    c.steps      = 8'(steps);
    c.start_lvl  = 6'(start_lvl);
    c.target_lvl = 6'(target_lvl);
    c.planes     = 6'(planes);
    fade_cmds.push_back(c);
  endtask

  task automatic queue_random_cmd();
    queue_cmd(op_e'($urandom_range(0, 3)), $urandom_range(0, 3), $urandom_range(0, 255),
              rand_level(), rand_level(), $urandom_range(0, 63));
  endtask

  // ------------------------------------------------------------- predictor

  function automatic bright_beat_t write_beat(int i, bit [5:0] planes, int level);
    bright_beat_t b;
    b             = '{default: '0};
    b.write_valid = 1'b1;
    b.screen      = i[0];
    b.plane_mask  = planes;
    b.level       = level[5:0];
    return b;
  endfunction

  // One tick of the DDA ramp; returns 1 when the channel reached its target.
  function automatic bit ramp_tick(int i);
    int dir;
    bit done;
    dir  = chan[i].down ? -1 : 1;
    done = 1'b0;
    if (chan[i].level + dir * chan[i].quot != chan[i].target &&
        chan[i].level != chan[i].target) begin
      chan[i].level += dir * chan[i].quot;
      chan[i].acc   += chan[i].rem;
      if (chan[i].acc >= chan[i].steps) begin
        chan[i].level += dir;
        if (chan[i].level != chan[i].target) chan[i].acc -= chan[i].steps;
        else done = 1'b1;
      end
    end else begin
      // next whole step lands on (or we already sit at) the target: snap
      chan[i].level = chan[i].target;
      done          = 1'b1;
    end
    chan[i].acc &= 511;
    return done;
  endfunction

  function automatic void predict_fade(fade_cmd_t c);
    bright_beat_t beats[$];
    bright_beat_t b;
    bit           err;
    bit           done;
    int           s;
    int           t;
    int           diff;
    int           mag;
    err = 1'b0;
    s   = int'(c.start_lvl);
    t   = int'(c.target_lvl);
    for (int i = 0; i < 2; i++) begin
      case (c.op)
        OP_TICK: begin
          if (chan[i].busy) begin
            done = ramp_tick(i);
            beats.push_back(write_beat(i, chan[i].planes, chan[i].level));
            if (done) chan[i].busy = 1'b0;
          end
        end
        OP_START: begin
          // zero steps drops the start entirely
          if (c.screens[i] && c.steps != 0) begin
            if (chan[i].busy) err = 1'b1;
            beats.push_back(write_beat(i, c.planes, s));
            diff           = s - t;
            chan[i].down   = diff > 0;
            mag            = (diff > 0) ? diff : -diff;
            chan[i].level  = s;
            chan[i].target = t;
            chan[i].steps  = int'(c.steps);
            chan[i].planes = c.planes;
            chan[i].quot   = (mag / int'(c.steps)) & 63;
            chan[i].rem    = mag % int'(c.steps);
            chan[i].acc    = 0;
            chan[i].busy   = 1'b1;
          end
        end
        default: begin
          if (c.screens[i]) begin
            if (c.op == OP_SET) beats.push_back(write_beat(i, c.planes, s));
            chan[i] = '{default: 0};
          end
        end
      endcase
    end
    // status-only beat when nothing was written
    if (beats.size() == 0) beats.push_back('{default: '0});
    foreach (beats[k]) begin
      b           = beats[k];
      b.busy_main = chan[0].busy;
      b.busy_sub  = chan[1].busy;
      b.error     = err;
      b.last      = (k == beats.size() - 1);
      bright_due.push_back(b);
    end
  endfunction

  // --------------------------------------------------------------- stimulus

  initial begin
    int scr;
    int n;
    int ticks;

    // directed: idle tick, full-swing fades, zero steps, equal levels,
    // restart of a busy channel, set-now, cancel, empty screen mask
    queue_cmd(OP_TICK,   3, 0,   0,   0,   0);
    queue_cmd(OP_START,  3, 1,   -16, 16,  63);
    queue_cmd(OP_TICK,   0, 0,   0,   0,   0);
    queue_cmd(OP_START,  1, 0,   4,   -4,  7);
    queue_cmd(OP_START,  2, 4,   5,   5,   0);
    queue_cmd(OP_TICK,   3, 255, 0,   0,   0);
    queue_cmd(OP_START,  1, 3,   16,  -16, 42);
    queue_cmd(OP_START,  1, 255, 16,  -16, 21);
    queue_cmd(OP_TICK,   0, 0,   0,   0,   0);
    queue_cmd(OP_TICK,   0, 0,   0,   0,   0);
    queue_cmd(OP_START,  2, 7,   -3,  9,   13);
    queue_cmd(OP_TICK,   0, 0,   0,   0,   0);
    queue_cmd(OP_TICK,   0, 0,   0,   0,   0);
    queue_cmd(OP_TICK,   0, 0,   0,   0,   0);
    queue_cmd(OP_SET,    1, 0,   -16, 0,   63);
    queue_cmd(OP_CANCEL, 2, 0,   0,   0,   0);
    queue_cmd(OP_TICK,   3, 0,   0,   0,   0);
    queue_cmd(OP_START,  0, 5,   3,   -3,  9);
    queue_cmd(OP_SET,    0, 0,   7,   0,   9);
    queue_cmd(OP_CANCEL, 3, 0,   0,   0,   0);
    queue_cmd(OP_SET,    3, 0,   16,  0,   0);
    queue_cmd(OP_START,  3, 2,   0,   1,   36);
    queue_cmd(OP_TICK,   0, 0,   0,   0,   0);
    queue_cmd(OP_TICK,   0, 0,   0,   0,   0);
    queue_cmd(OP_TICK,   0, 0,   0,   0,   0);

    // random: mostly a start followed by its ticks, with noise mixed in
    while (fade_cmds.size() < 1500) begin
      if ($urandom_range(0, 99) < 70) begin
        scr = $urandom_range(1, 3);
        n   = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 255) : $urandom_range(1, 12);
        queue_cmd(OP_START, scr, n, rand_level(), rand_level(), $urandom_range(0, 63));
        ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n + $urandom_range(0, 3);
        for (int k = 0; k < ticks; k++) begin
          if ($urandom_range(0, 99) < 6) queue_random_cmd();
          else queue_cmd(OP_TICK, $urandom_range(0, 3), $urandom_range(0, 255), rand_level(),
                         rand_level(), $urandom_range(0, 63));
        end
      end else begin
        queue_random_cmd();
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------- driver

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || cmd_taken)) begin
      cmd_taken = 1'b0;
      if (fade_cmds.size() != 0 && (quiet || $urandom_range(0, 99) >= 27)) begin
        cur_cmd         = fade_cmds.pop_front();
        in_valid_i     <= 1'b1;
        op_i           <= cur_cmd.op;
        screens_i      <= cur_cmd.screens;
        steps_i        <= cur_cmd.steps;
        start_level_i  <= cur_cmd.start_lvl;
        target_level_i <= cur_cmd.target_lvl;
        planes_i       <= cur_cmd.planes;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= rst_ni && !quiet && ($urandom_range(0, 99) < 27);
  end

  // --------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    bright_beat_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_fade(cur_cmd);
        n_taken++;
        cmd_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (bright_due.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = bright_due.pop_front();
          check_field("write_valid", 6'(write_valid_o), 6'(want.write_valid));
          check_field("screen",      6'(screen_o),      6'(want.screen));
          check_field("plane_mask",  plane_mask_o,      want.plane_mask);
          check_field("level",       level_o,           want.level);
          check_field("busy_main",   6'(busy_main_o),   6'(want.busy_main));
          check_field("busy_sub",    6'(busy_sub_o),    6'(want.busy_sub));
          check_field("error",       6'(error_o),       6'(want.error));
          check_field("last",        6'(last_o),        6'(want.last));
        end
      end
    end
  end

  // ------------------------------------------------------------ end of test

  initial begin
    wait (rst_ni);
    wait (fade_cmds.size() == 0 && !in_valid_i);
    for (int c = 0; c < 20000 && bright_due.size() != 0; c++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (bright_due.size() != 0)
      report_mismatch($sformatf("%0d result beats never arrived", bright_due.size()));
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
